// ----- rtl/core/lrar_pkg.sv -----
package lrar_pkg;

  // Ring geometry.
  localparam int RING_LEDS    = 30;
  localparam int LED_W        = 5;
  localparam int STEP_DEGREES = 12;
  localparam int FULL_TURN    = 360;
  localparam int COLOR_W      = 24;
  localparam int ANGLE_W      = 9;
  localparam int STEPS_W      = 5;

  // Quadrant boundaries in degrees and the first LED of each block.
  localparam int QUAD_1_DEG   = 90;
  localparam int QUAD_2_DEG   = 180;
  localparam int QUAD_3_DEG   = 270;
  localparam int QUAD_SPAN    = 7;
  localparam logic [LED_W-1:0] QUAD_0_FIRST = 5'd1;
  localparam logic [LED_W-1:0] QUAD_1_FIRST = 5'd8;
  localparam logic [LED_W-1:0] QUAD_2_FIRST = 5'd16;
  localparam logic [LED_W-1:0] QUAD_3_FIRST = 5'd23;

  // Division by 3 (after a shift by 2, giving division by STEP_DEGREES) as a
  // reciprocal multiply; exact for dividends below 512.
  localparam int RECIP_3       = 171;
  localparam int RECIP_3_SHIFT = 9;

  // Division by 45 (after a shift by 3, giving division by FULL_TURN); exact
  // for dividends below 2260.
  localparam int RECIP_45       = 1457;
  localparam int RECIP_45_SHIFT = 16;

  // Segment width for each step count: RING_LEDS / steps, zero for zero steps.
  localparam logic [LED_W-1:0] SEG_WIDTH [32] = '{
    5'd0,  5'd30, 5'd15, 5'd10, 5'd7,  5'd6,  5'd5,  5'd4,
    5'd3,  5'd3,  5'd3,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,
    5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,
    5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd0
  };

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISABLE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEPS   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRONT   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACK    = 3'd6;

  // Rendering modes.
  localparam logic [1:0] MODE_ARC    = 2'd0;
  localparam logic [1:0] MODE_QUAD   = 2'd1;
  localparam logic [1:0] MODE_SEG    = 2'd2;
  localparam logic [1:0] MODE_REPLAY = 2'd3;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_ARC = 1'b1;

endpackage

// ----- rtl/core/led_ring_angle_renderer_top.sv -----
// Path: an accepted item goes from ST_CALC straight to ST_RUN in modes 1 and 3 and when
// disabled, through ST_ARC in mode 0 (to ST_ERR for an error item) and through ST_SEG_K,
// ST_DIV (a serial divider) and ST_SEG_CHK (the overrun check) in mode 2. No new item is
// taken until the single LED counter has walked the 30-entry frame memory, one entry a cycle
// while the read stage can advance, or the item has ended in an error item or no result.
// Reset: synchronous, clears control and configuration; the frame memory reads as zero
// until the first frame is written, through one stored-valid flag, with no clearing pass.
module led_ring_angle_renderer_top
  import lrar_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ANGLE_W-1:0]     rotation_angle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LED_W-1:0]       led_index,
  output logic [COLOR_W-1:0]     color,
  output logic [LED_W-1:0]       segment_offset,
  output logic                   status,
  output logic                   last
);

  localparam int DIV_BITS = 10;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CALC, ST_ARC, ST_SEG_K, ST_DIV, ST_SEG_CHK, ST_ERR, ST_RUN
  } state_t;

  typedef enum logic [1:0] {FK_ZERO, FK_ARC, FK_LIT, FK_REPLAY} frame_kind_t;

  // Configuration registers.
  logic                 disable_cfg;
  logic [1:0]           mode;
  logic [ANGLE_W-1:0]   arc_start;
  logic [ANGLE_W-1:0]   arc_stop;
  logic [STEPS_W-1:0]   step_count;
  logic [COLOR_W-1:0]   fg_color;
  logic [COLOR_W-1:0]   bg_color;

  // Sequencer and per-frame registers.
  state_t               state;
  frame_kind_t          kind;
  logic [ANGLE_W-1:0]   rot;
  logic [5:0]           s_idx;
  logic [5:0]           e_idx;
  logic [LED_W-1:0]     lit_lo;
  logic [5:0]           lit_hi;
  logic                 wrap;
  logic [9:0]           ang;
  logic [13:0]          seg_prod;
  logic [DIV_BITS-1:0]  div_q;
  logic [LED_W-1:0]     div_rem;
  logic [3:0]           div_cnt;
  logic [LED_W-1:0]     frame_off;
  logic [LED_W-1:0]     led_cnt;
  logic                 store_valid;

  // Stage between the memory read and the output register.
  logic                 p1_valid;
  logic [LED_W-1:0]     p1_idx;
  logic [COLOR_W-1:0]   p1_color;
  logic                 p1_from_mem;
  logic                 p1_mem_ok;
  logic [LED_W-1:0]     p1_off;
  logic                 p1_status;
  logic                 p1_last;

  // Frame memory.
  logic [COLOR_W-1:0]   frame_mem [RING_LEDS];
  logic [COLOR_W-1:0]   rd_data;

  // Combinational helpers.
  logic                 out_adv;
  logic                 p1_adv;
  logic                 issue;
  logic                 mem_we;
  logic                 mem_re;
  logic [9:0]           s_sum;
  logic [9:0]           e_sum;
  logic [15:0]          s_prod;
  logic [15:0]          e_prod;
  logic [21:0]          k_prod;
  logic [5:0]           seg_k;
  logic [5:0]           rem_sh;
  logic                 rem_ge;
  logic [10:0]          ovr_lhs;
  logic [10:0]          ovr_rhs;
  logic [5:0]           led6;
  logic                 in_lo;
  logic                 in_hi;
  logic                 in_range;
  logic [5:0]           arc_i;
  logic [9:0]           arc_deg;
  logic [COLOR_W-1:0]   stage_color;

  assign in_ready = (state == ST_IDLE);
  assign out_adv  = !out_valid || out_ready;
  assign p1_adv   = !p1_valid || out_adv;
  assign issue    = p1_adv && ((state == ST_RUN) || (state == ST_ERR));
  assign mem_we   = p1_adv && (state == ST_RUN) && (kind != FK_REPLAY);
  assign mem_re   = p1_adv && (state == ST_RUN) && (kind == FK_REPLAY);

  // Arc end points rounded to LEDs: (angle + 6) / 12 as (x >> 2) / 3.
  assign s_sum  = 10'(arc_start) + 10'(STEP_DEGREES / 2);
  assign e_sum  = 10'(arc_stop) + 10'(STEP_DEGREES / 2);
  assign s_prod = 16'(s_sum[9:2]) * 16'(RECIP_3);
  assign e_prod = 16'(e_sum[9:2]) * 16'(RECIP_3);

  // Segment number: (angle * steps) / 360 as (x >> 3) / 45.
  assign k_prod = 22'(seg_prod[13:3]) * 22'(RECIP_45);
  assign seg_k  = 6'(k_prod >> RECIP_45_SHIFT);

  // One restoring division step of the segment offset.
  assign rem_sh = {div_rem, div_q[DIV_BITS-1]};
  assign rem_ge = rem_sh >= {1'b0, step_count};

  // Segment overrun: offset * steps + 30 > 30 * steps.
  assign ovr_lhs = 11'(div_q[LED_W-1:0]) * 11'(step_count) + 11'(RING_LEDS);
  assign ovr_rhs = 11'(step_count * 10'(RING_LEDS));

  // Color of the LED at the counter for rendered frames.
  assign led6     = {1'b0, led_cnt};
  assign in_lo    = led6 >= {1'b0, lit_lo};
  assign in_hi    = led6 < lit_hi;
  assign in_range = wrap ? (in_lo || in_hi) : (in_lo && in_hi);
  assign arc_i    = (wrap && in_hi) ? led6 + 6'(RING_LEDS) : led6;
  assign arc_deg  = 10'({arc_i, 3'b000}) + 10'({arc_i, 2'b00});

  always_comb begin
    unique case (kind)
      FK_ZERO:   stage_color = '0;
      FK_ARC:    stage_color = in_range ? ((ang > arc_deg) ? fg_color : bg_color) : '0;
      FK_LIT:    stage_color = in_range ? fg_color : '0;
      FK_REPLAY: stage_color = '0;
      default:   stage_color = '0;
    endcase
  end

  // Frame memory: one write or one registered read per cycle, both at the LED counter.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[led_cnt] <= stage_color;
    end
    if (mem_re) begin
      rd_data <= frame_mem[led_cnt];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      disable_cfg <= 1'b0;
      mode        <= MODE_ARC;
      arc_start   <= '0;
      arc_stop    <= ANGLE_W'(FULL_TURN);
      step_count  <= STEPS_W'(1);
      fg_color    <= '0;
      bg_color    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DISABLE: disable_cfg <= cfg_wr_data[0];
        CFG_MODE:    mode        <= cfg_wr_data[1:0];
        CFG_START:   arc_start   <= cfg_wr_data[ANGLE_W-1:0];
        CFG_STOP:    arc_stop    <= cfg_wr_data[ANGLE_W-1:0];
        CFG_STEPS:   step_count  <= cfg_wr_data[STEPS_W-1:0];
        CFG_FRONT:   fg_color    <= cfg_wr_data;
        CFG_BACK:    bg_color    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Sequencer, read stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      kind        <= FK_ZERO;
      store_valid <= 1'b0;
      p1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      led_cnt     <= '0;
      div_cnt     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rot   <= rotation_angle;
            state <= ST_CALC;
          end
        end

        // Decode the mode and do the first arithmetic step.
        ST_CALC: begin
          led_cnt   <= '0;
          frame_off <= '0;
          wrap      <= 1'b0;
          if (disable_cfg) begin
            kind  <= FK_ZERO;
            state <= ST_RUN;
          end else begin
            unique case (mode)
              MODE_ARC: begin
                kind  <= FK_ARC;
                s_idx <= 6'(s_prod >> RECIP_3_SHIFT);
                e_idx <= 6'(e_prod >> RECIP_3_SHIFT);
                state <= ST_ARC;
              end
              MODE_QUAD: begin
                kind <= FK_LIT;
                priority if (rot < ANGLE_W'(QUAD_1_DEG)) begin
                  lit_lo <= QUAD_0_FIRST;
                  lit_hi <= 6'(QUAD_0_FIRST) + 6'(QUAD_SPAN);
                  state  <= ST_RUN;
                end else if (rot < ANGLE_W'(QUAD_2_DEG)) begin
                  lit_lo <= QUAD_1_FIRST;
                  lit_hi <= 6'(QUAD_1_FIRST) + 6'(QUAD_SPAN);
                  state  <= ST_RUN;
                end else if (rot < ANGLE_W'(QUAD_3_DEG)) begin
                  lit_lo <= QUAD_2_FIRST;
                  lit_hi <= 6'(QUAD_2_FIRST) + 6'(QUAD_SPAN);
                  state  <= ST_RUN;
                end else if (rot <= ANGLE_W'(FULL_TURN)) begin
                  lit_lo <= QUAD_3_FIRST;
                  lit_hi <= 6'(QUAD_3_FIRST) + 6'(QUAD_SPAN);
                  state  <= ST_RUN;
                end else begin
                  state <= ST_IDLE;
                end
              end
              MODE_SEG: begin
                kind     <= FK_LIT;
                seg_prod <= 14'(rot) * 14'(step_count);
                if (rot > ANGLE_W'(FULL_TURN) || step_count == '0) begin
                  state <= ST_IDLE;
                end else begin
                  state <= ST_SEG_K;
                end
              end
              MODE_REPLAY: begin
                kind  <= FK_REPLAY;
                state <= ST_RUN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end

        // Check the arc and handle a start beyond the stop.
        ST_ARC: begin
          if (s_idx >= 6'(RING_LEDS) || e_idx > 6'(RING_LEDS)) begin
            state <= ST_ERR;
          end else begin
            lit_lo <= s_idx[LED_W-1:0];
            lit_hi <= e_idx;
            wrap   <= s_idx > e_idx;
            if (s_idx > e_idx && rot < arc_stop) begin
              ang <= 10'(rot) + 10'(FULL_TURN);
            end else begin
              ang <= 10'(rot);
            end
            state <= ST_RUN;
          end
        end

        // Load the divider with k * 30.
        ST_SEG_K: begin
          div_q   <= DIV_BITS'(seg_k * 10'(RING_LEDS));
          div_rem <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end

        ST_DIV: begin
          div_rem <= rem_ge ? LED_W'(rem_sh - {1'b0, step_count}) : rem_sh[LED_W-1:0];
          div_q   <= {div_q[DIV_BITS-2:0], rem_ge};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(DIV_BITS - 1)) begin
            state <= ST_SEG_CHK;
          end
        end

        ST_SEG_CHK: begin
          if (ovr_lhs > ovr_rhs) begin
            state <= ST_IDLE;
          end else begin
            frame_off <= div_q[LED_W-1:0];
            lit_lo    <= div_q[LED_W-1:0];
            lit_hi    <= 6'(div_q[LED_W-1:0]) + 6'(SEG_WIDTH[step_count]);
            state     <= ST_RUN;
          end
        end

        ST_ERR: begin
          if (p1_adv) begin
            state <= ST_IDLE;
          end
        end

        ST_RUN: begin
          if (p1_adv) begin
            led_cnt <= led_cnt + 5'd1;
            if (led_cnt == LED_W'(RING_LEDS - 1)) begin
              state <= ST_IDLE;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase

      if (mem_we) begin
        store_valid <= 1'b1;
      end

      // Read stage: one LED or the error item per issue.
      if (p1_adv) begin
        p1_valid <= issue;
      end
      if (issue) begin
        if (state == ST_ERR) begin
          p1_idx      <= '0;
          p1_color    <= '0;
          p1_from_mem <= 1'b0;
          p1_off      <= '0;
          p1_status   <= STATUS_BAD_ARC;
          p1_last     <= 1'b1;
        end else begin
          p1_idx      <= led_cnt;
          p1_color    <= stage_color;
          p1_from_mem <= (kind == FK_REPLAY);
          p1_mem_ok   <= store_valid;
          p1_off      <= frame_off;
          p1_status   <= STATUS_OK;
          p1_last     <= (led_cnt == LED_W'(RING_LEDS - 1));
        end
      end

      // Output register.
      if (out_adv) begin
        out_valid <= p1_valid;
        if (p1_valid) begin
          led_index      <= p1_idx;
          color          <= p1_from_mem ? (p1_mem_ok ? rd_data : '0) : p1_color;
          segment_offset <= p1_off;
          status         <= p1_status;
          last           <= p1_last;
        end
      end
    end
  end

  // An error item always closes its frame.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_BAD_ARC) |-> last)
    else $error("error item without last");

  // A frame of LEDs ends on the last ring position.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last && status == STATUS_OK) |-> (led_index == LED_W'(RING_LEDS - 1)))
    else $error("last flag on wrong LED");

  // The frame memory is either rendered or replayed, never both at once.
  assert property (@(posedge clk) disable iff (rst) !(mem_we && mem_re))
    else $error("frame memory written and read together");

  // An accepted item closes the input until its work is done.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened right after accept");

endmodule

// ----- dv/tb_led_ring_angle_renderer_top.sv -----
module tb_led_ring_angle_renderer_top;
  import lrar_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index past the last register; writes to it must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [LED_W-1:0]   led_index;
    logic [COLOR_W-1:0] color;
    logic [LED_W-1:0]   seg_offset;
    logic               status;
    logic               last;
  } led_result_t;

  typedef struct {
    logic               dis;
    logic [1:0]         mode;
    logic [ANGLE_W-1:0] start_deg;
    logic [ANGLE_W-1:0] stop_deg;
    logic [STEPS_W-1:0] steps;
    logic [COLOR_W-1:0] front;
    logic [COLOR_W-1:0] back;
  } ring_cfg_t;

  // Shadow of the renderer: register copy, stored frame and the LED results still owed.
  class frame_scoreboard;
    logic               dis_r = 1'b0;
    logic [1:0]         mode_r = MODE_ARC;
    logic [ANGLE_W-1:0] start_r = '0;
    logic [ANGLE_W-1:0] stop_r = ANGLE_W'(360);
    logic [STEPS_W-1:0] steps_r = STEPS_W'(1);
    logic [COLOR_W-1:0] front_r = '0;
    logic [COLOR_W-1:0] back_r = '0;
    logic [COLOR_W-1:0] ring_frame [RING_LEDS];
    led_result_t        expected_leds [$];
    int                 mismatches = 0;

    function void clear_frame();
      foreach (ring_frame[i]) ring_frame[i] = '0;
    endfunction

    function int pending();
      return expected_leds.size();
    endfunction

    function void write_reg(int idx, logic [COLOR_W-1:0] data);
      case (CFG_INDEX_W'(idx))
        CFG_DISABLE: dis_r = data[0];
        CFG_MODE:    mode_r = data[1:0];
        CFG_START:   start_r = data[ANGLE_W-1:0];
        CFG_STOP:    stop_r = data[ANGLE_W-1:0];
        CFG_STEPS:   steps_r = data[STEPS_W-1:0];
        CFG_FRONT:   front_r = data;
        CFG_BACK:    back_r = data;
        default: ;
      endcase
    endfunction

    // The whole stored frame goes out, LED 0 first, last flag on the final LED.
    function void queue_frame(int offset);
      led_result_t r;
      for (int i = 0; i < RING_LEDS; i++) begin
        r.led_index = LED_W'(i);
        r.color = ring_frame[i];
        r.seg_offset = LED_W'(offset);
        r.status = STATUS_OK;
        r.last = (i == RING_LEDS - 1);
        expected_leds.push_back(r);
      end
    endfunction

    // Renders one accepted angle and queues the LED results it produces.
    function void render_angle(logic [ANGLE_W-1:0] rot);
      int s, e, a, k, offset, width, first, steps, i;
      led_result_t r;
      if (dis_r) begin
        clear_frame();
        queue_frame(0);
        return;
      end
      case (mode_r)
        MODE_ARC: begin
          s = (int'(start_r) + STEP_DEGREES / 2) / STEP_DEGREES;
          e = (int'(stop_r) + STEP_DEGREES / 2) / STEP_DEGREES;
          // An arc end past the ring gives a single error item; the frame is kept.
          if (s >= RING_LEDS || e > RING_LEDS) begin
            r = '0;
            r.status = STATUS_BAD_ARC;
            r.last = 1'b1;
            expected_leds.push_back(r);
            return;
          end
          a = int'(rot);
          if (s > e) begin
            e += RING_LEDS;
            if (rot < stop_r) a = int'(rot) + FULL_TURN;
          end
          clear_frame();
          for (i = s; i < e; i++)
            ring_frame[i % RING_LEDS] = (a > i * STEP_DEGREES) ? front_r : back_r;
          queue_frame(0);
        end
        MODE_QUAD: begin
          if (rot > FULL_TURN) return;
          // Seven LEDs per quarter turn; LEDs 0 and 15 always stay dark.
          if (rot < 90) first = 1;
          else if (rot < 180) first = 8;
          else if (rot < 270) first = 16;
          else first = 23;
          clear_frame();
          for (i = first; i < first + 7; i++) ring_frame[i] = front_r;
          queue_frame(0);
        end
        MODE_SEG: begin
          steps = int'(steps_r);
          if (rot > FULL_TURN || steps == 0) return;
          k = (int'(rot) * steps) / FULL_TURN;
          offset = (k * RING_LEDS) / steps;
          // A segment that would start past the last full one is dropped.
          if (offset * steps + RING_LEDS > RING_LEDS * steps) return;
          width = RING_LEDS / steps;
          clear_frame();
          for (i = 0; i < width && offset + i < RING_LEDS; i++)
            ring_frame[offset + i] = front_r;
          queue_frame(offset);
        end
        default: queue_frame(0);
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      // Keep the log readable when everything goes wrong at once.
      if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(led_result_t got);
      led_result_t want;
      string diff;
      if (expected_leds.size() == 0) begin
        report_mismatch($sformatf("unexpected item led %0d color %06h status %0b",
                                  got.led_index, got.color, got.status));
        return;
      end
      want = expected_leds.pop_front();
      diff = "";
      if (got.led_index !== want.led_index) diff = {diff, " led_index"};
      if (got.color !== want.color) diff = {diff, " color"};
      if (got.seg_offset !== want.seg_offset) diff = {diff, " segment_offset"};
      if (got.status !== want.status) diff = {diff, " status"};
      if (got.last !== want.last) diff = {diff, " last"};
      if (diff != "")
        report_mismatch($sformatf(
          "%s: got %0d/%06h/%0d/%0b/%0b want %0d/%06h/%0d/%0b/%0b", diff,
          got.led_index, got.color, got.seg_offset, got.status, got.last,
          want.led_index, want.color, want.seg_offset, want.status, want.last));
    endtask
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]     cfg_wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ANGLE_W-1:0]     rotation_angle = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [LED_W-1:0]       led_index;
  logic [COLOR_W-1:0]     color;
  logic [LED_W-1:0]       segment_offset;
  logic                   status;
  logic                   last;

  frame_scoreboard sb;
  int unsigned     angle_list [$];
  int              send_busy = 0;
  int              recv_busy = 0;
  int              hold_cycles = 0;
  int              stall_count = 0;

  led_ring_angle_renderer_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rotation_angle (rotation_angle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .led_index      (led_index),
    .color          (color),
    .segment_offset (segment_offset),
    .status         (status),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random idle wait, taken on the given percentage of items.
  function automatic int draw_gap(int busy_pct);
    return (int'($urandom_range(99)) < busy_pct) ? int'($urandom_range(15)) : 0;
  endfunction

  function automatic int unsigned draw_angle();
    return ($urandom_range(6) == 0) ? $urandom_range(511, 361) : $urandom_range(360);
  endfunction

  task automatic send_angle(input logic [ANGLE_W-1:0] a, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rotation_angle <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.render_angle(a);
  endtask

  // Stop offering items, let every owed result arrive, then let silent work finish.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input ring_cfg_t c);
    logic [COLOR_W-1:0] word [8];
    word[CFG_DISABLE] = COLOR_W'(c.dis);
    word[CFG_MODE]    = COLOR_W'(c.mode);
    word[CFG_START]   = COLOR_W'(c.start_deg);
    word[CFG_STOP]    = COLOR_W'(c.stop_deg);
    word[CFG_STEPS]   = COLOR_W'(c.steps);
    word[CFG_FRONT]   = c.front;
    word[CFG_BACK]    = c.back;
    word[CFG_UNUSED]  = COLOR_W'($urandom());
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_wr_data <= word[i];
      @(posedge clk);
      sb.write_reg(i, word[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input ring_cfg_t c, input int hold);
    drain_block();
    set_config(c);
    hold_cycles = hold;
    foreach (angle_list[i]) send_angle(ANGLE_W'(angle_list[i]), draw_gap(send_busy));
  endtask

  // Result side: random back-pressure, plus an occasional long hold-off.
  initial begin : result_sink
    int gap;
    led_result_t got;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = draw_gap(recv_busy);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.led_index = led_index;
      got.color = color;
      got.seg_offset = segment_offset;
      got.status = status;
      got.last = last;
      sb.check_result(got);
    end
  end

  // A run that stops moving items for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin : stimulus
    ring_cfg_t c;
    int n_random;
    int phase;
    int hold;
    sb = new;
    sb.clear_frame();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, light idling on both sides.
    send_busy = 25;
    recv_busy = 25;

    // Replay before any frame was rendered reads back a dark ring.
    c = '{dis: 1'b0, mode: MODE_REPLAY, start_deg: '0, stop_deg: ANGLE_W'(360),
          steps: STEPS_W'(1), front: '1, back: '0};
    angle_list = {0};
    run_phase(c, 0);

    // Full arc; an angle above a full turn is used as given.
    c.mode = MODE_ARC;
    angle_list = {0, 12, 360, 511};
    run_phase(c, 0);

    // Arc wrapping through LED 0, colours swapped.
    c.start_deg = ANGLE_W'(300);
    c.stop_deg = ANGLE_W'(60);
    c.front = '0;
    c.back = '1;
    angle_list = {0, 59, 300, 359};
    run_phase(c, 0);

    // Invalid arcs: start rounds onto LED 30, then stop rounds past it.
    c.start_deg = ANGLE_W'(354);
    c.stop_deg = ANGLE_W'(360);
    angle_list = {100};
    run_phase(c, 0);
    c.start_deg = '0;
    c.stop_deg = ANGLE_W'(366);
    run_phase(c, 0);

    // Quadrant edges and out-of-range angles that give no result.
    c.mode = MODE_QUAD;
    c.front = 24'h5A3CC3;
    angle_list = {0, 90, 180, 269, 360, 361, 511};
    run_phase(c, 0);

    // Stepped segment: zero steps, a count wider than the ring, then one LED per step.
    c.mode = MODE_SEG;
    c.steps = '0;
    angle_list = {100};
    run_phase(c, 0);
    c.steps = STEPS_W'(31);
    angle_list = {0, 360};
    run_phase(c, 0);
    c.steps = STEPS_W'(30);
    angle_list = {0, 360, 359};
    run_phase(c, 0);

    // Replay the last segment, then disable clears the stored frame.
    c.mode = MODE_REPLAY;
    angle_list = {5};
    run_phase(c, 0);
    c.dis = 1'b1;
    angle_list = {200};
    run_phase(c, 0);
    c.dis = 1'b0;
    angle_list = {7};
    run_phase(c, 0);

    // Random phases, each with its own settings and idling pattern.
    n_random = 0;
    phase = 0;
    while (n_random < 300) begin
      c.dis = ($urandom_range(9) == 0);
      c.mode = 2'($urandom_range(3));
      c.start_deg = ANGLE_W'(($urandom_range(4) == 0) ? $urandom_range(511)
                                                       : $urandom_range(360));
      c.stop_deg = ANGLE_W'(($urandom_range(4) == 0) ? $urandom_range(511)
                                                      : $urandom_range(360));
      c.steps = STEPS_W'(($urandom_range(5) == 0) ? $urandom_range(31)
                                                   : $urandom_range(30, 1));
      c.front = COLOR_W'($urandom());
      c.back = COLOR_W'($urandom());
      send_busy = 33 * int'($urandom_range(3));
      recv_busy = 33 * int'($urandom_range(3));
      hold = 0;
      // One phase backs up the output while items keep coming in.
      if (phase == 1) begin
        c.dis = 1'b0;
        c.mode = MODE_REPLAY;
        send_busy = 0;
        hold = 300;
      end
      angle_list = {};
      repeat ($urandom_range(24, 8)) angle_list.push_back(draw_angle());
      run_phase(c, hold);
      n_random += angle_list.size();
      phase++;
    end

    drain_block();
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
